// ===== design/tiled_framebuffer_dirty_tracker_defines.svh =====
// assertion macros used by the dirty tracker back end
`ifndef TILED_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH
`define TILED_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TFDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/tfdt_pkg.sv =====
// shared types and constants of the dirty tile tracker
`timescale 1ns / 1ps
package tfdt_pkg;
    localparam int TileSize  = 64;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int CoordW    = 12;
    localparam int DimW      = 11;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FILL = 2'd1,
        OP_NEXT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SET_RD,
        ST_SET_WR,
        ST_FILL,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_DONE
    } t_state;

    // classified command passed from front to back
    typedef struct packed {
        t_op                op;
        logic               empty;
        logic [CoordW-1:0]  x0;
        logic [CoordW-1:0]  y0;
        logic [CoordW-1:0]  x1;
        logic [CoordW-1:0]  y1;
        logic [31:0]        colour;
    } t_cmd;

    typedef struct packed {
        logic       changed;
        logic       tile_found;
        logic [3:0] tile_col;
        logic [3:0] tile_row;
        logic [6:0] tile_width;
        logic [6:0] tile_height;
    } t_res;
endpackage

// ===== design/tfdt_front.sv =====
// front end: orders, clamps and range checks incoming words
`timescale 1ns / 1ps
module tfdt_front #(
    parameter int MAX_WIDTH  = tfdt_pkg::MaxWidth,
    parameter int MAX_HEIGHT = tfdt_pkg::MaxHeight
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [tfdt_pkg::CoordW-1:0] i_xs,
    input  logic [tfdt_pkg::CoordW-1:0] i_ys,
    input  logic [tfdt_pkg::CoordW-1:0] i_xe,
    input  logic [tfdt_pkg::CoordW-1:0] i_ye,
    input  logic [31:0]                i_colour,
    input  logic [tfdt_pkg::DimW-1:0]  i_w,
    input  logic [tfdt_pkg::DimW-1:0]  i_h,
    output logic                       o_valid,
    input  logic                       i_ready,
    output tfdt_pkg::t_cmd             o_cmd
);
    localparam int CW = tfdt_pkg::CoordW;
    localparam int DW = tfdt_pkg::DimW;

    logic signed [CW:0] xs, ys, xe, ye, lo_x, hi_x, lo_y, hi_y, w, h;
    logic [DW-1:0]      aw, ah;
    logic               r_valid;
    tfdt_pkg::t_cmd     r_cmd, n_cmd;

    // classify the word
    always_comb begin
        xs = {i_xs[CW-1], i_xs};
        ys = {i_ys[CW-1], i_ys};
        xe = {i_xe[CW-1], i_xe};
        ye = {i_ye[CW-1], i_ye};
        // active screen size: zero acts as one, large values stop at the maximum
        aw = (i_w == '0) ? DW'(1) : ((i_w > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : i_w);
        ah = (i_h == '0) ? DW'(1) : ((i_h > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : i_h);
        w = $signed({2'b00, aw});
        h = $signed({2'b00, ah});
        n_cmd = '0;
        n_cmd.op = tfdt_pkg::t_op'(i_op);
        n_cmd.colour = i_colour;
        if (i_op == tfdt_pkg::OP_FILL) begin
            lo_x = (xs > xe) ? xe : xs;
            hi_x = (xs > xe) ? xs : xe;
            lo_y = (ys > ye) ? ye : ys;
            hi_y = (ys > ye) ? ys : ye;
        end else begin
            lo_x = xs;
            hi_x = xs;
            lo_y = ys;
            hi_y = ys;
        end
        if (lo_x < 0) lo_x = '0;
        if (lo_y < 0) lo_y = '0;
        if (hi_x >= w) hi_x = w - $signed((CW + 1)'(1));
        if (hi_y >= h) hi_y = h - $signed((CW + 1)'(1));
        n_cmd.empty = (lo_x > hi_x) || (lo_y > hi_y);
        if (i_op == tfdt_pkg::OP_SET) begin
            n_cmd.empty = (xs < 0) || (xs >= w) || (ys < 0) || (ys >= h);
        end
        n_cmd.x0 = lo_x[CW-1:0];
        n_cmd.y0 = lo_y[CW-1:0];
        n_cmd.x1 = hi_x[CW-1:0];
        n_cmd.y1 = hi_y[CW-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    // one entry queue to the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// ===== design/tfdt_back.sv =====
// back end: pixel memory, dirty bits and the operation sequencer
`timescale 1ns / 1ps
`include "tiled_framebuffer_dirty_tracker_defines.svh"
module tfdt_back #(
    parameter int TILE_SIZE  = tfdt_pkg::TileSize,
    parameter int MAX_WIDTH  = tfdt_pkg::MaxWidth,
    parameter int MAX_HEIGHT = tfdt_pkg::MaxHeight
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  tfdt_pkg::t_cmd            i_cmd,
    input  logic [tfdt_pkg::DimW-1:0] i_w,
    input  logic [tfdt_pkg::DimW-1:0] i_h,
    output logic                      o_valid,
    input  logic                      i_ready,
    output tfdt_pkg::t_res            o_res
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int TW    = $clog2(TILE_SIZE);
    localparam int COLS  = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int ROWS  = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NT    = COLS * ROWS;
    localparam int NTW   = $clog2(NT + 1);
    localparam int TIW   = (NT > 1) ? $clog2(NT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CLW   = tfdt_pkg::CoordW;
    localparam int DW    = tfdt_pkg::DimW;

    logic [31:0]     mem [DEPTH];
    logic            dirty_mem [NT];
    logic [31:0]     r_rd;
    logic            r_dirty_rd;
    tfdt_pkg::t_state r_state, n_state;
    tfdt_pkg::t_cmd  r_cmd;
    logic [AW:0]     r_clr;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [CW-1:0]   r_c;
    logic [RW-1:0]   r_r;
    tfdt_pkg::t_res  r_res;
    tfdt_pkg::t_res  r_out;
    logic            r_out_valid;

    logic [DW-1:0]   aw, ah;
    logic [DW-1:0]   cols, rows;
    logic [AW-1:0]   addr;
    logic            wr_en;
    logic [31:0]     wr_data;
    logic [AW-1:0]   wr_addr;
    logic            take, finish;
    logic [NTW-1:0]  tidx, pidx;
    logic [TIW-1:0]  scan_idx, pix_idx;
    logic            d_we, d_data;
    logic [TIW-1:0]  d_addr;
    logic [DW:0]     tw_full, th_full;

    // clamp the screen size
    always_comb begin
        aw = (i_w == '0) ? DW'(1) : ((i_w > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : i_w);
        ah = (i_h == '0) ? DW'(1) : ((i_h > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : i_h);
        cols = DW'((aw + DW'(TILE_SIZE - 1)) >> TW);
        rows = DW'((ah + DW'(TILE_SIZE - 1)) >> TW);
    end

    assign take     = (r_state == tfdt_pkg::ST_IDLE) && i_valid;
    assign o_ready  = (r_state == tfdt_pkg::ST_IDLE);
    assign addr     = {r_y, r_x};
    assign tidx     = NTW'(r_r) * NTW'(COLS) + NTW'(r_c);
    assign pidx     = NTW'(r_y >> TW) * NTW'(COLS) + NTW'(r_x >> TW);
    assign scan_idx = tidx[TIW-1:0];
    assign pix_idx  = pidx[TIW-1:0];
    assign finish   = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfdt_pkg::ST_CLEAR:
                if (r_clr == (AW + 1)'(DEPTH - 1)) n_state = tfdt_pkg::ST_IDLE;
            tfdt_pkg::ST_IDLE:
                if (i_valid) begin
                    if (i_cmd.op == tfdt_pkg::OP_SET && !i_cmd.empty)
                        n_state = tfdt_pkg::ST_SET_RD;
                    else if (i_cmd.op == tfdt_pkg::OP_FILL && !i_cmd.empty)
                        n_state = tfdt_pkg::ST_FILL;
                    else if (i_cmd.op == tfdt_pkg::OP_NEXT)
                        n_state = tfdt_pkg::ST_SCAN;
                    else
                        n_state = tfdt_pkg::ST_DONE;
                end
            tfdt_pkg::ST_SET_RD: n_state = tfdt_pkg::ST_SET_WR;
            tfdt_pkg::ST_SET_WR: n_state = tfdt_pkg::ST_DONE;
            tfdt_pkg::ST_FILL:
                if (CLW'(r_x) == r_cmd.x1 && CLW'(r_y) == r_cmd.y1)
                    n_state = tfdt_pkg::ST_DONE;
            tfdt_pkg::ST_SCAN: n_state = tfdt_pkg::ST_SCAN_CHK;
            tfdt_pkg::ST_SCAN_CHK:
                if (r_dirty_rd || (DW'(r_c) == cols - 1'b1 && DW'(r_r) == rows - 1'b1))
                    n_state = tfdt_pkg::ST_DONE;
                else
                    n_state = tfdt_pkg::ST_SCAN;
            tfdt_pkg::ST_DONE:
                if (finish) n_state = tfdt_pkg::ST_IDLE;
            default: n_state = tfdt_pkg::ST_IDLE;
        endcase
    end

    // memory write control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_data = r_cmd.colour;
        case (r_state)
            tfdt_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr[AW-1:0];
                wr_data = '0;
            end
            tfdt_pkg::ST_SET_WR: wr_en = (r_rd != r_cmd.colour);
            tfdt_pkg::ST_FILL:   wr_en = 1'b1;
            default:             wr_en = 1'b0;
        endcase
    end

    // pixel memory, one port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[wr_addr];
    end

    // dirty flag write control: set during clearing and drawing, cleared when a scan reports the tile
    always_comb begin
        d_we   = 1'b0;
        d_addr = pix_idx;
        d_data = 1'b1;
        case (r_state)
            tfdt_pkg::ST_CLEAR: begin
                d_we   = 1'b1;
                d_addr = r_clr[TIW-1:0];
            end
            tfdt_pkg::ST_SET_WR: d_we = (r_rd != r_cmd.colour);
            tfdt_pkg::ST_FILL:   d_we = 1'b1;
            tfdt_pkg::ST_SCAN_CHK: begin
                d_we   = r_dirty_rd;
                d_addr = scan_idx;
                d_data = 1'b0;
            end
            default: d_we = 1'b0;
        endcase
    end

    // dirty flag memory
    always_ff @(posedge i_clk) begin
        if (d_we) dirty_mem[d_addr] <= d_data;
        r_dirty_rd <= dirty_mem[scan_idx];
    end

    // tile size clipped at screen edge
    always_comb begin
        tw_full = {1'b0, aw} - ((DW + 1)'(r_c) << TW);
        th_full = {1'b0, ah} - ((DW + 1)'(r_r) << TW);
        if (tw_full > (DW + 1)'(TILE_SIZE)) tw_full = (DW + 1)'(TILE_SIZE);
        if (th_full > (DW + 1)'(TILE_SIZE)) th_full = (DW + 1)'(TILE_SIZE);
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfdt_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tfdt_pkg::ST_DONE && finish) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                tfdt_pkg::ST_CLEAR: r_clr <= r_clr + 1'b1;
                tfdt_pkg::ST_IDLE:
                    if (take) begin
                        r_cmd <= i_cmd;
                        r_x   <= XW'(i_cmd.x0);
                        r_y   <= YW'(i_cmd.y0);
                        r_c   <= '0;
                        r_r   <= '0;
                        r_res <= '0;
                    end
                tfdt_pkg::ST_SET_WR:
                    if (r_rd != r_cmd.colour) r_res.changed <= 1'b1;
                tfdt_pkg::ST_FILL: begin
                    r_res.changed <= 1'b1;
                    if (CLW'(r_x) == r_cmd.x1) begin
                        r_x <= XW'(r_cmd.x0);
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                tfdt_pkg::ST_SCAN_CHK:
                    if (r_dirty_rd) begin
                        r_res.tile_found  <= 1'b1;
                        r_res.tile_col    <= 4'(r_c);
                        r_res.tile_row    <= 4'(r_r);
                        r_res.tile_width  <= 7'(tw_full);
                        r_res.tile_height <= 7'(th_full);
                    end else if (DW'(r_c) == cols - 1'b1) begin
                        r_c <= '0;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                // result register lets the next word start while this one waits
                tfdt_pkg::ST_DONE:
                    if (finish) r_out <= r_res;
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `TFDT_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != tfdt_pkg::ST_IDLE, !o_ready)
    `TFDT_ASSERT_NXT(a_found_done, i_clk, i_rst_n, (r_state == tfdt_pkg::ST_SCAN_CHK) && r_dirty_rd, r_state == tfdt_pkg::ST_DONE)
    `TFDT_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_res))
    `TFDT_ASSERT_IMP(a_res_excl, i_clk, i_rst_n, o_valid, !(o_res.changed && o_res.tile_found))
endmodule

// ===== design/tiled_framebuffer_dirty_tracker.sv =====
// top level of the tiled frame buffer with dirty tile tracking
`timescale 1ns / 1ps
// Frame buffer of MAX_WIDTH x MAX_HEIGHT RGBA pixels in one single-port memory, split
// into TILE_SIZE square tiles with a dirty flag each, kept in a small memory of its own.
// After reset a clearing pass writes zero to every pixel and sets every dirty flag,
// while no word is taken. A word is registered in the front queue. The sequencer then
// steps a set pixel through take, read, compare and write, and result; a fill writes
// each pixel of the clamped rectangle in turn, row by row; a next-dirty scan reads
// and then checks the flag of each tile visited; a dropped or unused word goes
// straight to the result. A finished result waits in an output register, so the
// next word can run meanwhile.
module tiled_framebuffer_dirty_tracker #(
    parameter int TILE_SIZE  = tfdt_pkg::TileSize,
    parameter int MAX_WIDTH  = tfdt_pkg::MaxWidth,
    parameter int MAX_HEIGHT = tfdt_pkg::MaxHeight
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], x_start[13:2], y_start[25:14], x_end[37:26], y_end[49:38],
    // red[57:50], green[65:58], blue[73:66], alpha[81:74], zero fill to 88
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // changed[0], tile_found[1], tile_col[5:2], tile_row[9:6],
    // tile_width[16:10], tile_height[23:17]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    logic [10:0]    r_w, r_h;
    logic           f_valid, b_ready, b_valid;
    tfdt_pkg::t_cmd cmd;
    tfdt_pkg::t_res res;

    assign o_cfg_ready = 1'b1;

    // screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd1024;
            r_h <= 11'd1024;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tfdt_pkg::REG_SCREEN_WIDTH)  r_w <= i_cfg_data;
            if (i_cfg_index == tfdt_pkg::REG_SCREEN_HEIGHT) r_h <= i_cfg_data;
        end
    end

    tfdt_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[1:0]), .i_xs(s_axis_tdata[13:2]), .i_ys(s_axis_tdata[25:14]),
        .i_xe(s_axis_tdata[37:26]), .i_ye(s_axis_tdata[49:38]),
        .i_colour(s_axis_tdata[81:50]), .i_w(r_w), .i_h(r_h),
        .o_valid(f_valid), .i_ready(b_ready), .o_cmd(cmd)
    );

    tfdt_back #(.TILE_SIZE(TILE_SIZE), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT))
    u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(b_ready), .i_cmd(cmd),
        .i_w(r_w), .i_h(r_h),
        .o_valid(b_valid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {res.tile_height, res.tile_width, res.tile_row,
                            res.tile_col, res.tile_found, res.changed};
endmodule
